### hdl/swlf_pkg.sv
// ----------------------------------------------------------------------------
// swlf_pkg
// shared types and fixed constants of the sliding window line fit core
// ----------------------------------------------------------------------------
package swlf_pkg;

  // fraction bits of the fit results and their width
  localparam int FRAC_BITS      = 16;
  localparam int OUT_W          = 48;
  // window length register
  localparam int CFG_W          = 7;
  localparam int DEFAULT_WINDOW = 10;

  // sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_SUB  = 6'b010000,
    ST_DONE = 6'b100000
  } swlf_state_e;

  // products formed by the shared multiplier, in issue order
  typedef enum logic [2:0] {
    OP_N_SXX  = 3'd0,
    OP_SX_SX  = 3'd1,
    OP_N_SXY  = 3'd2,
    OP_SX_SY  = 3'd3,
    OP_SY_SXX = 3'd4,
    OP_SX_SXY = 3'd5
  } swlf_op_e;

  // start and completion of a multi-cycle arithmetic unit
  typedef struct packed {
    logic start;
  } swlf_req_t;

  typedef struct packed {
    logic done;
  } swlf_rsp_t;

endpackage

### hdl/swlf_mul.sv
// ----------------------------------------------------------------------------
// swlf_mul
// serial signed multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module swlf_mul #(
  parameter int A_W = 38,
  parameter int B_W = 23
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  swlf_pkg::swlf_req_t      req_i,
  input  logic signed [A_W-1:0]    a_i,
  input  logic signed [B_W-1:0]    b_i,
  output swlf_pkg::swlf_rsp_t      rsp_o,
  output logic signed [A_W+B_W:0]  prod_o
);

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = $clog2(B_W + 1);

  logic [A_W-1:0]   mag_a;
  logic [B_W-1:0]   mag_b;
  logic [P_W-1:0]   acc_q;
  logic [P_W-1:0]   mc_q;
  logic [B_W-1:0]   mp_q;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic             busy_q;
  logic             done_q;

  assign mag_a = a_i[A_W-1] ? A_W'(-a_i) : A_W'(a_i);
  assign mag_b = b_i[B_W-1] ? B_W'(-b_i) : B_W'(b_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      mc_q   <= '0;
      mp_q   <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        acc_q  <= '0;
        mc_q   <= P_W'(mag_a);
        mp_q   <= mag_b;
        cnt_q  <= CNT_W'(B_W);
        neg_q  <= a_i[A_W-1] ^ b_i[B_W-1];
        busy_q <= 1'b1;
      end else if (busy_q) begin
        if (mp_q[0]) begin
          acc_q <= acc_q + mc_q;
        end
        mc_q  <= mc_q << 1;
        mp_q  <= mp_q >> 1;
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done = done_q;
  assign prod_o     = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});

endmodule

### hdl/swlf_div.sv
// ----------------------------------------------------------------------------
// swlf_div
// serial restoring divider, rounded fixed-point ratio with saturation
// ----------------------------------------------------------------------------
module swlf_div #(
  parameter int N_W = 62
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  swlf_pkg::swlf_req_t               req_i,
  input  logic signed [N_W-1:0]             num_i,
  input  logic signed [N_W-1:0]             den_i,
  output swlf_pkg::swlf_rsp_t               rsp_o,
  output logic signed [swlf_pkg::OUT_W-1:0] quo_o
);

  localparam int Q_W   = swlf_pkg::OUT_W;
  localparam int D_W   = N_W + swlf_pkg::FRAC_BITS + 1;
  localparam int CNT_W = $clog2(D_W + 1);

  logic [N_W-1:0]   mag_n;
  logic [N_W-1:0]   mag_d;
  logic [D_W-1:0]   quo_q;
  logic [N_W:0]     rem_q;
  logic [N_W:0]     dd_q;
  logic [N_W+1:0]   trial;
  logic             ge;
  logic [CNT_W-1:0] cnt_q;
  logic             neg_q;
  logic             busy_q;
  logic             done_q;
  logic [D_W-1:0]   lim;
  logic [Q_W-1:0]   qmag;

  assign mag_n = num_i[N_W-1] ? N_W'(-num_i) : N_W'(num_i);
  assign mag_d = den_i[N_W-1] ? N_W'(-den_i) : N_W'(den_i);
  assign trial = {rem_q, quo_q[D_W-1]};
  assign ge    = trial >= {1'b0, dd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quo_q  <= '0;
      rem_q  <= '0;
      dd_q   <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        // half a divisor added so the truncating divide rounds to nearest
        quo_q  <= (D_W'(mag_n) << (swlf_pkg::FRAC_BITS + 1)) + D_W'(mag_d);
        rem_q  <= '0;
        dd_q   <= {mag_d, 1'b0};
        cnt_q  <= CNT_W'(D_W);
        neg_q  <= num_i[N_W-1] ^ den_i[N_W-1];
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= ge ? (N_W+1)'(trial - {1'b0, dd_q}) : trial[N_W:0];
        quo_q <= {quo_q[D_W-2:0], ge};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // saturate to the largest magnitude of the result sign
  assign lim   = neg_q ? (D_W'(1) << (Q_W - 1)) : ((D_W'(1) << (Q_W - 1)) - D_W'(1));
  assign qmag  = (quo_q > lim) ? lim[Q_W-1:0] : quo_q[Q_W-1:0];
  assign quo_o = neg_q ? -$signed(qmag) : $signed(qmag);
  assign rsp_o.done = done_q;

endmodule

### hdl/sliding_window_line_fit_core.sv
// ----------------------------------------------------------------------------
// sliding_window_line_fit_core
// least-squares line fit over the newest window_length points
// ----------------------------------------------------------------------------
// Each input transfer carries one signed point (x, y). The point goes into a
// ring memory and into exact running sums of n, x, x*x, y and x*y; the line
// y = slope*x + intercept is then fitted over those sums and one result
// transfer gives slope and intercept in signed Q31.16 (rounded to nearest,
// ties away from zero, saturated to 48 bits) with fit_valid. When
// n*Sxx - Sx*Sx is zero, fit_valid is low and the last valid fit is repeated
// (zero before the first). Once the window is full the oldest point leaves
// the sums after the fit. Writing the window length (0 acts as 1, values
// above MAX_WINDOW act as MAX_WINDOW) restarts the window; only write it
// while no point is in flight. Six products run through one shared serial
// multiplier and the two ratios (not formed for a degenerate fit) through
// one shared serial divider, one bit per cycle. A finished result sits in an
// output register, so the block takes the next point while it waits to be
// taken.
module sliding_window_line_fit_core #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // point input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]     x_value_i,
  input  logic signed [SAMPLE_BITS-1:0]     y_value_i,
  // fit output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [swlf_pkg::OUT_W-1:0] slope_o,
  output logic signed [swlf_pkg::OUT_W-1:0] intercept_o,
  output logic                              fit_valid_o,
  // window length register
  input  logic                              cfg_we_i,
  input  logic [swlf_pkg::CFG_W-1:0]        cfg_data_i
);

  localparam int S   = SAMPLE_BITS;
  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int WLW = $clog2(MAX_WINDOW + 1);
  localparam int W1  = S + AW + 1;       // sums of x and y
  localparam int W2  = 2 * S + AW;       // sums of x*x and x*y
  localparam int PW  = W1 + W2 + 1;      // products and fit numerators
  localparam int OW  = swlf_pkg::OUT_W;
  localparam int RST_WL = (swlf_pkg::DEFAULT_WINDOW > MAX_WINDOW) ? MAX_WINDOW
                                                                   : swlf_pkg::DEFAULT_WINDOW;

  swlf_pkg::swlf_state_e state_q;
  swlf_pkg::swlf_op_e    op_q;

  // ring memory, x in the upper half of each entry
  logic [2*S-1:0] ring_mem [MAX_WINDOW];
  logic [2*S-1:0] rd_q;

  logic [WLW-1:0]      wl_q;
  logic [WLW-1:0]      wl_d;
  logic [AW-1:0]       cnt_q;
  logic [AW-1:0]       slot_q;
  logic [AW-1:0]       nxt_slot;
  logic                full_q;
  logic                fwd_q;
  logic                in_xfer;
  logic signed [S-1:0] x_q;
  logic signed [S-1:0] y_q;
  logic signed [S-1:0] ox_q;
  logic signed [S-1:0] oy_q;
  logic signed [S-1:0] old_x;
  logic signed [S-1:0] old_y;

  logic signed [W1-1:0] sx_q;
  logic signed [W1-1:0] sy_q;
  logic signed [W2-1:0] sxx_q;
  logic signed [W2-1:0] sxy_q;
  logic signed [W1-1:0] n_val;

  logic signed [2*S-1:0] new_xx;
  logic signed [2*S-1:0] new_xy;
  logic signed [2*S-1:0] old_xx;
  logic signed [2*S-1:0] old_xy;

  logic signed [PW-1:0] den_q;
  logic signed [PW-1:0] ns_q;
  logic signed [PW-1:0] ni_q;
  logic                 issued_q;
  logic                 icpt_sel_q;

  logic signed [OW-1:0] held_slope_q;
  logic signed [OW-1:0] held_icpt_q;
  logic                 fit_q;

  logic                 out_valid_q;
  logic signed [OW-1:0] slope_q;
  logic signed [OW-1:0] icpt_q;
  logic                 out_fit_q;

  // arithmetic units
  swlf_pkg::swlf_req_t  mul_req;
  swlf_pkg::swlf_rsp_t  mul_rsp;
  logic signed [W2-1:0] mul_a;
  logic signed [W1-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  swlf_pkg::swlf_req_t  div_req;
  swlf_pkg::swlf_rsp_t  div_rsp;
  logic signed [PW-1:0] div_num;
  logic signed [OW-1:0] div_q;

  assign in_ready_o = (state_q == swlf_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;

  // slot after the write slot: the oldest point once the window is full
  assign nxt_slot = (WLW'(slot_q) + WLW'(1) == wl_q) ? '0 : slot_q + AW'(1);

  // clamp the written window length into 1 .. MAX_WINDOW
  always_comb begin
    if (cfg_data_i == '0) begin
      wl_d = WLW'(1);
    end else if (int'(cfg_data_i) > MAX_WINDOW) begin
      wl_d = WLW'(MAX_WINDOW);
    end else begin
      wl_d = WLW'(cfg_data_i);
    end
  end

  // ring memory: write the new point, read the oldest one in the same cycle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      ring_mem[slot_q] <= {x_value_i, y_value_i};
    end
    rd_q <= ring_mem[nxt_slot];
  end

  // with a window of one the oldest point is the one just written
  assign old_x = fwd_q ? x_q : $signed(rd_q[2*S-1:S]);
  assign old_y = fwd_q ? y_q : $signed(rd_q[S-1:0]);

  assign new_xx = x_q * x_q;
  assign new_xy = x_q * y_q;
  assign old_xx = ox_q * ox_q;
  assign old_xy = ox_q * oy_q;

  // points in the window including the new one
  assign n_val = W1'(cnt_q) + W1'(1);

  // operand selection for the shared multiplier
  always_comb begin
    case (op_q)
      swlf_pkg::OP_N_SXX: begin
        mul_a = sxx_q;
        mul_b = n_val;
      end
      swlf_pkg::OP_SX_SX: begin
        mul_a = W2'(sx_q);
        mul_b = sx_q;
      end
      swlf_pkg::OP_N_SXY: begin
        mul_a = sxy_q;
        mul_b = n_val;
      end
      swlf_pkg::OP_SX_SY: begin
        mul_a = W2'(sy_q);
        mul_b = sx_q;
      end
      swlf_pkg::OP_SY_SXX: begin
        mul_a = sxx_q;
        mul_b = sy_q;
      end
      swlf_pkg::OP_SX_SXY: begin
        mul_a = sxy_q;
        mul_b = sx_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_req.start = (state_q == swlf_pkg::ST_MUL) && !issued_q;
  assign div_req.start = (state_q == swlf_pkg::ST_DIV) && !issued_q;
  assign div_num       = icpt_sel_q ? ni_q : ns_q;

  swlf_mul #(
    .A_W (W2),
    .B_W (W1)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .rsp_o  (mul_rsp),
    .prod_o (mul_p)
  );

  swlf_div #(
    .N_W (PW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .num_i  (div_num),
    .den_i  (den_q),
    .rsp_o  (div_rsp),
    .quo_o  (div_q)
  );

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= swlf_pkg::ST_IDLE;
      op_q         <= swlf_pkg::OP_N_SXX;
      wl_q         <= WLW'(RST_WL);
      cnt_q        <= '0;
      slot_q       <= '0;
      full_q       <= 1'b0;
      fwd_q        <= 1'b0;
      x_q          <= '0;
      y_q          <= '0;
      ox_q         <= '0;
      oy_q         <= '0;
      sx_q         <= '0;
      sy_q         <= '0;
      sxx_q        <= '0;
      sxy_q        <= '0;
      den_q        <= '0;
      ns_q         <= '0;
      ni_q         <= '0;
      issued_q     <= 1'b0;
      icpt_sel_q   <= 1'b0;
      held_slope_q <= '0;
      held_icpt_q  <= '0;
      fit_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      slope_q      <= '0;
      icpt_q       <= '0;
      out_fit_q    <= 1'b0;
    end else begin
      // result taken; in ST_DONE the output register is handled below
      if (out_valid_q && out_ready_i && (state_q != swlf_pkg::ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        swlf_pkg::ST_IDLE: begin
          if (cfg_we_i) begin
            // new window length restarts the window
            wl_q   <= wl_d;
            cnt_q  <= '0;
            slot_q <= '0;
            sx_q   <= '0;
            sy_q   <= '0;
            sxx_q  <= '0;
            sxy_q  <= '0;
          end else if (in_xfer) begin
            x_q     <= x_value_i;
            y_q     <= y_value_i;
            fwd_q   <= (nxt_slot == slot_q);
            state_q <= swlf_pkg::ST_LOAD;
          end
        end
        swlf_pkg::ST_LOAD: begin
          // oldest point arrives from the memory; add the new one
          ox_q     <= old_x;
          oy_q     <= old_y;
          sx_q     <= sx_q + W1'(x_q);
          sy_q     <= sy_q + W1'(y_q);
          sxx_q    <= sxx_q + W2'(new_xx);
          sxy_q    <= sxy_q + W2'(new_xy);
          full_q   <= (WLW'(cnt_q) + WLW'(1) == wl_q);
          op_q     <= swlf_pkg::OP_N_SXX;
          issued_q <= 1'b0;
          state_q  <= swlf_pkg::ST_MUL;
        end
        swlf_pkg::ST_MUL: begin
          if (!issued_q) begin
            issued_q <= 1'b1;
          end else if (mul_rsp.done) begin
            issued_q <= 1'b0;
            case (op_q)
              swlf_pkg::OP_N_SXX:  den_q <= mul_p;
              swlf_pkg::OP_SX_SX:  den_q <= den_q - mul_p;
              swlf_pkg::OP_N_SXY:  ns_q  <= mul_p;
              swlf_pkg::OP_SX_SY:  ns_q  <= ns_q - mul_p;
              swlf_pkg::OP_SY_SXX: ni_q  <= mul_p;
              swlf_pkg::OP_SX_SXY: ni_q  <= ni_q - mul_p;
              default:             den_q <= den_q;
            endcase
            if (op_q == swlf_pkg::OP_SX_SXY) begin
              icpt_sel_q <= 1'b0;
              if (den_q == '0) begin
                // degenerate fit: keep the held line
                fit_q   <= 1'b0;
                state_q <= swlf_pkg::ST_SUB;
              end else begin
                state_q <= swlf_pkg::ST_DIV;
              end
            end else begin
              op_q <= swlf_pkg::swlf_op_e'(op_q + 3'd1);
            end
          end
        end
        swlf_pkg::ST_DIV: begin
          if (!issued_q) begin
            issued_q <= 1'b1;
          end else if (div_rsp.done) begin
            issued_q <= 1'b0;
            if (!icpt_sel_q) begin
              held_slope_q <= div_q;
              icpt_sel_q   <= 1'b1;
            end else begin
              held_icpt_q <= div_q;
              fit_q       <= 1'b1;
              state_q     <= swlf_pkg::ST_SUB;
            end
          end
        end
        swlf_pkg::ST_SUB: begin
          // drop the oldest point once the window is full
          if (full_q) begin
            sx_q  <= sx_q - W1'(ox_q);
            sy_q  <= sy_q - W1'(oy_q);
            sxx_q <= sxx_q - W2'(old_xx);
            sxy_q <= sxy_q - W2'(old_xy);
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
          slot_q  <= nxt_slot;
          state_q <= swlf_pkg::ST_DONE;
        end
        swlf_pkg::ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            slope_q     <= held_slope_q;
            icpt_q      <= held_icpt_q;
            out_fit_q   <= fit_q;
            out_valid_q <= 1'b1;
            state_q     <= swlf_pkg::ST_IDLE;
          end
        end
        default: begin
          state_q <= swlf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign slope_o     = slope_q;
  assign intercept_o = icpt_q;
  assign fit_valid_o = out_fit_q;

endmodule

### test/tb_sliding_window_line_fit_core.sv
// ----------------------------------------------------------------------------
// tb_sliding_window_line_fit_core
// self-checking bench for the sliding window least-squares line fit core
// ----------------------------------------------------------------------------
// Points go in through a valid/ready channel and fits come out through
// another. A scoreboard keeps its own window sums and rounding divider and
// predicts slope, intercept and fit_valid for every accepted point, then
// checks each fit transfer against the oldest prediction. The window length
// register is written between phases, once nothing is in flight, and both
// sides idle at random, with one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_sliding_window_line_fit_core;

  localparam int MAX_WIN   = 64;
  localparam int SMP_W     = 16;
  localparam int CNT_FOLD  = 4;
  localparam int HOLD_LEN  = 3000;
  localparam int TAIL_WAIT = 400;

  // one predicted fit
  typedef struct {
    logic signed [swlf_pkg::OUT_W-1:0] slope;
    logic signed [swlf_pkg::OUT_W-1:0] intercept;
    logic                              fit_ok;
  } fit_t;

  // --------------------------------------------------------------------------
  // fit predictor and result store
  // --------------------------------------------------------------------------
  class fit_scoreboard;
    int unsigned win_len;
    int unsigned pts_seen;
    longint      win_x [MAX_WIN];
    longint      win_y [MAX_WIN];
    longint      s_n, s_x, s_xx, s_y, s_xy;
    longint      last_slope, last_icpt;
    fit_t        pending_fits[$];
    int          errors;

    function new();
      win_len    = swlf_pkg::DEFAULT_WINDOW;
      last_slope = 0;
      last_icpt  = 0;
      errors     = 0;
      restart();
    endfunction

    function void restart();
      pts_seen = 0;
      s_n = 0; s_x = 0; s_xx = 0; s_y = 0; s_xy = 0;
    endfunction

    // register write: clamp to 1..MAX_WIN and restart the window
    function void set_window(logic [swlf_pkg::CFG_W-1:0] v);
      win_len = (v == 0) ? 1 : (v > MAX_WIN) ? MAX_WIN : v;
      restart();
    endfunction

    // round(num * 2^16 / den), ties away from zero, saturated to 48 bits
    function longint fixed_quot(longint num, longint den);
      logic [127:0] mag_n, mag_d, q, lim;
      bit           neg;
      neg   = (num < 0) != (den < 0);
      mag_n = (num < 0) ? 128'(-num) : 128'(num);
      mag_d = (den < 0) ? 128'(-den) : 128'(den);
      q     = ((mag_n << (swlf_pkg::FRAC_BITS + 1)) + mag_d) / (mag_d << 1);
      lim   = neg ? (128'(1) << (swlf_pkg::OUT_W - 1))
                  : ((128'(1) << (swlf_pkg::OUT_W - 1)) - 1);
      if (q > lim) q = lim;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // accepted point: update the window and queue the expected fit
    function void note_point(logic signed [SMP_W-1:0] xv, logic signed [SMP_W-1:0] yv);
      longint      px, py, den, ox, oy;
      int unsigned slot;
      fit_t        f;
      px   = xv;
      py   = yv;
      slot = pts_seen % win_len;
      win_x[slot] = px;
      win_y[slot] = py;
      s_n  += 1;
      s_x  += px;
      s_xx += px * px;
      s_y  += py;
      s_xy += px * py;
      den = s_n * s_xx - s_x * s_x;
      f.fit_ok = (den != 0);
      if (den != 0) begin
        last_slope = fixed_quot(s_n * s_xy - s_x * s_y, den);
        last_icpt  = fixed_quot(s_xx * s_y - s_x * s_xy, den);
      end
      // oldest point leaves once the window is full
      if (pts_seen + 1 >= win_len) begin
        slot = (pts_seen + 1) % win_len;
        ox = win_x[slot];
        oy = win_y[slot];
        s_n  -= 1;
        s_x  -= ox;
        s_xx -= ox * ox;
        s_y  -= oy;
        s_xy -= ox * oy;
        pts_seen++;
        if (pts_seen == CNT_FOLD * win_len) pts_seen = win_len;
      end else begin
        pts_seen++;
      end
      f.slope     = last_slope[swlf_pkg::OUT_W-1:0];
      f.intercept = last_icpt[swlf_pkg::OUT_W-1:0];
      pending_fits.push_back(f);
    endfunction

    task report(string what, longint got, longint want);
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_fit(logic signed [swlf_pkg::OUT_W-1:0] sl,
                   logic signed [swlf_pkg::OUT_W-1:0] ic, logic ok);
      fit_t f;
      if (pending_fits.size() == 0) begin
        report("unexpected fit transfer", 0, 0);
        return;
      end
      f = pending_fits.pop_front();
      if (sl !== f.slope)     report("slope", sl, f.slope);
      if (ic !== f.intercept) report("intercept", ic, f.intercept);
      if (ok !== f.fit_ok)    report("fit_valid", ok, f.fit_ok);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, dut
  // --------------------------------------------------------------------------
  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic signed [SMP_W-1:0]           x_value_i = '0;
  logic signed [SMP_W-1:0]           y_value_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic signed [swlf_pkg::OUT_W-1:0] slope_o;
  logic signed [swlf_pkg::OUT_W-1:0] intercept_o;
  logic                              fit_valid_o;
  logic                              cfg_we_i = 1'b0;
  logic [swlf_pkg::CFG_W-1:0]        cfg_data_i = '0;

  fit_scoreboard sb = new();
  bit            hold_req = 1'b0;  // ask the receiver for one long hold-off
  bit            no_idle  = 1'b0;  // phases with back-to-back transfers

  always #6 clk_i = ~clk_i;

  sliding_window_line_fit_core #(
    .MAX_WINDOW (MAX_WIN),
    .SAMPLE_BITS(SMP_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .x_value_i  (x_value_i),
    .y_value_i  (y_value_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .slope_o    (slope_o),
    .intercept_o(intercept_o),
    .fit_valid_o(fit_valid_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------
  // offer one point; valid stays high into the next call when no gap follows
  task automatic send_point(logic signed [SMP_W-1:0] xv, logic signed [SMP_W-1:0] yv);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    x_value_i  = xv;
    y_value_i  = yv;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    sb.note_point(xv, yv);
    @(negedge clk_i);
  endtask

  // wait until every expected fit has come back
  task automatic drain();
    in_valid_i = 1'b0;
    while (sb.pending_fits.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_window(logic [swlf_pkg::CFG_W-1:0] v);
    drain();
    cfg_we_i   = 1'b1;
    cfg_data_i = v;
    @(posedge clk_i);
    sb.set_window(v);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // random point, mixing full range, clustered x and extremes
  task automatic send_random(ref logic signed [SMP_W-1:0] prev_x);
    logic signed [SMP_W-1:0] xv, yv;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: xv = SMP_W'($urandom);
      6, 7:             xv = SMP_W'($urandom_range(0, 8) - 4);
      8:                xv = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default:          xv = prev_x;  // repeated x drives degenerate fits
    endcase
    case ($urandom_range(0, 5))
      0:       yv = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1:       yv = SMP_W'($urandom_range(0, 16) - 8);
      default: yv = SMP_W'($urandom);
    endcase
    prev_x = xv;
    send_point(xv, yv);
  endtask

  // --------------------------------------------------------------------------
  // output side
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = HOLD_LEN;
      end
      if (stall > 0) begin
        out_ready_i = 1'b0;
        stall--;
      end else begin
        stall       = pick_gap();
        out_ready_i = (stall == 0);
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) sb.check_fit(slope_o, intercept_o, fit_valid_o);
    end
  end

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [swlf_pkg::CFG_W-1:0] win_set[$];
    logic signed [SMP_W-1:0]    prev_x;
    int                         n_items;
    prev_x = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    // directed, reset window of ten: extremes, degenerate runs, large intercept
    send_point(16'sh8000, 16'sh8000);  // single point, degenerate
    send_point(16'sh7fff, 16'sh7fff);
    send_point(16'sh7fff, 16'sh8000);
    send_point(16'sh8000, 16'sh7fff);
    drain();
    write_window(7'd3);
    // same x throughout: degenerate, held fit repeated
    repeat (5) send_point(16'sh0005, SMP_W'($urandom));
    write_window(7'd2);
    // near-equal large x with opposite extreme y gives intercepts close to saturation
    send_point(16'sh7fff, 16'sh7fff);
    send_point(16'sh7ffe, 16'sh8000);
    send_point(16'sh7fff, 16'sh8000);
    send_point(16'sh8001, 16'sh7fff);
    send_point(16'sh8000, 16'sh8000);
    write_window(7'd1);
    // window of one: always degenerate
    send_point(16'sh0001, 16'sh0002);
    send_point(16'sh7fff, 16'sh8000);
    send_point(16'sh8000, 16'sh7fff);
    write_window(7'd0);  // taken as one
    send_point(16'sh1234, 16'sh4321);
    send_point(16'sh0000, 16'sh0000);

    // random phases over several window settings, extremes among them
    win_set = '{7'd64, 7'd127, 7'd10, 7'd2, 7'd65, 7'd1, 7'd0, 7'd63, 7'd5};
    repeat (4) win_set.push_back(swlf_pkg::CFG_W'($urandom_range(1, 127)));
    foreach (win_set[p]) begin
      write_window(win_set[p]);
      no_idle = (p % 4 == 3);
      n_items = 110;
      for (int k = 0; k < n_items; k++) begin
        // long output hold-off in the first phase while points keep coming
        if (p == 0 && k == 20) hold_req = 1'b1;
        // one pause until everything has drained, in mid phase
        if (p == 2 && k == 50) drain();
        send_random(prev_x);
      end
    end
    no_idle = 1'b0;

    drain();
    repeat (TAIL_WAIT) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending_fits.size() == 0) begin
      $display("** sliding_window_line_fit_core: PASSED **");
    end else begin
      $display("** sliding_window_line_fit_core: FAILED **");
    end
    $finish;
  end

  // timeout, far beyond the slowest legal run
  initial begin
    #60ms;
    $display("** sliding_window_line_fit_core: FAILED **");
    $finish;
  end

endmodule

### filelist.f
hdl/swlf_pkg.sv
hdl/swlf_mul.sv
hdl/swlf_div.sv
hdl/sliding_window_line_fit_core.sv
test/tb_sliding_window_line_fit_core.sv
